// ----- rtl/assert_macros.svh -----
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cbra_pkg.sv -----
package cbra_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int OWNER_COUNT = 8;

    localparam int IDX_W    = $clog2(ENTRY_COUNT);
    localparam int LEN_W    = $clog2(ENTRY_COUNT + 1);
    localparam int SPAN_W   = LEN_W + 1;
    localparam int OWN_W    = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
    localparam int DIM_W    = 4;
    localparam int PROD_W   = 2 * DIM_W;
    localparam int SLOT_W   = 3;
    localparam int START_W  = 6;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [SPAN_W-1:0]      span_t;
    typedef logic [OWN_W-1:0]       own_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [SLOT_W-1:0]      slot_t;
    typedef logic [START_W-1:0]     start_t;
    typedef logic [ENTRY_COUNT-1:0] map_t;
    typedef logic [OWNER_COUNT-1:0] use_t;

    typedef enum logic {
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_OWNER,
        ST_NO_ROOM,
        ST_NOT_USED
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MARK,
        S_DONE
    } state_t;

endpackage

// ----- rtl/contiguous_bitmap_region_allocator_unit.sv -----
// First-fit allocator of contiguous runs in an ENTRY_COUNT-slot bitmap for a
// table of OWNER_COUNT owners. An allocate takes the lowest idle owner and the
// first free run of row_count*column_count slots; a free releases an owner's
// run. The bitmap sits in a rotating shift register read one bit per cycle at
// its low end and rewritten at its high end. An allocate that finds room takes
// one full rotation to search and one to mark; a free of an owner in use takes
// one rotation to clear its run. Requests rejected at once (no idle owner,
// zero or oversized length, idle owner freed) skip the bitmap, and a failed
// search takes one rotation. One request is worked at a time; the result
// register lets the next request start while a result waits to be taken.
module contiguous_bitmap_region_allocator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [cbra_pkg::DIM_W-1:0]     s_row_count,
    input  logic [cbra_pkg::DIM_W-1:0]     s_column_count,
    input  logic [cbra_pkg::SLOT_W-1:0]    s_owner_slot,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cbra_pkg::STATUS_W-1:0]  m_status,
    output logic [cbra_pkg::SLOT_W-1:0]    m_granted_owner,
    output logic [cbra_pkg::START_W-1:0]   m_start_index
);

    cbra_pkg::state_t  state_reg, state_next;
    cbra_pkg::map_t    map_reg, map_next;
    cbra_pkg::use_t    in_use_reg, in_use_next;
    cbra_pkg::idx_t    idx_reg, idx_next;
    cbra_pkg::len_t    run_reg, run_next;
    logic              found_reg, found_next;
    cbra_pkg::idx_t    pos_reg, pos_next;
    cbra_pkg::len_t    len_reg, len_next;
    cbra_pkg::own_t    own_reg, own_next;
    cbra_pkg::idx_t    mstart_reg, mstart_next;
    logic              mval_reg, mval_next;
    cbra_pkg::status_t res_status_reg, res_status_next;
    cbra_pkg::slot_t   res_owner_reg, res_owner_next;
    cbra_pkg::start_t  res_start_reg, res_start_next;
    logic              m_valid_reg, m_valid_next;
    cbra_pkg::status_t m_status_reg, m_status_next;
    cbra_pkg::slot_t   m_owner_reg, m_owner_next;
    cbra_pkg::start_t  m_start_reg, m_start_next;

    cbra_pkg::idx_t    owner_start_mem [cbra_pkg::OWNER_COUNT];
    cbra_pkg::len_t    owner_length_mem [cbra_pkg::OWNER_COUNT];
    logic              tbl_we;
    cbra_pkg::idx_t    rd_start_reg;
    cbra_pkg::len_t    rd_len_reg;

    cbra_pkg::own_t    idle_own;
    logic              idle_found;
    cbra_pkg::prod_t   req_len;
    logic              len_ok;
    cbra_pkg::own_t    slot_idx;
    logic              slot_ok;
    cbra_pkg::len_t    run_inc;
    logic              last_idx;
    cbra_pkg::idx_t    span_start;
    cbra_pkg::len_t    span_len;
    logic              in_span;
    logic              new_bit;

    always_comb begin
        idle_own   = '0;
        idle_found = 1'b0;
        for (int i = cbra_pkg::OWNER_COUNT - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                idle_own   = cbra_pkg::own_t'(i);
                idle_found = 1'b1;
            end
        end
    end

    assign req_len  = cbra_pkg::prod_t'(s_row_count) * cbra_pkg::prod_t'(s_column_count);
    assign len_ok   = (req_len != '0) && (int'(req_len) <= cbra_pkg::ENTRY_COUNT);
    assign slot_idx = cbra_pkg::own_t'(s_owner_slot);
    assign slot_ok  = (int'(s_owner_slot) < cbra_pkg::OWNER_COUNT) && in_use_reg[slot_idx];
    assign run_inc  = run_reg + cbra_pkg::len_t'(1);
    assign last_idx = (idx_reg == cbra_pkg::idx_t'(cbra_pkg::ENTRY_COUNT - 1));
    assign span_start = mval_reg ? mstart_reg : rd_start_reg;
    assign span_len   = mval_reg ? len_reg : rd_len_reg;
    assign in_span  = (cbra_pkg::span_t'(idx_reg) >= cbra_pkg::span_t'(span_start))
                   && (cbra_pkg::span_t'(idx_reg) < cbra_pkg::span_t'(span_start)
                                                   + cbra_pkg::span_t'(span_len));
    assign new_bit  = in_span ? mval_reg : map_reg[0];

    always_comb begin
        state_next      = state_reg;
        map_next        = map_reg;
        in_use_next     = in_use_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        own_next        = own_reg;
        mstart_next     = mstart_reg;
        mval_next       = mval_reg;
        res_status_next = res_status_reg;
        res_owner_next  = res_owner_reg;
        res_start_next  = res_start_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_owner_next    = m_owner_reg;
        m_start_next    = m_start_reg;
        tbl_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cbra_pkg::S_IDLE: begin
                if (s_valid) begin
                    idx_next       = '0;
                    run_next       = '0;
                    found_next     = 1'b0;
                    res_start_next = '0;
                    if (cbra_pkg::op_t'(s_operation) == cbra_pkg::OP_ALLOC) begin
                        res_owner_next = '0;
                        if (!idle_found) begin
                            res_status_next = cbra_pkg::ST_NO_OWNER;
                            state_next      = cbra_pkg::S_DONE;
                        end else if (!len_ok) begin
                            res_status_next = cbra_pkg::ST_NO_ROOM;
                            state_next      = cbra_pkg::S_DONE;
                        end else begin
                            own_next   = idle_own;
                            len_next   = cbra_pkg::len_t'(req_len);
                            state_next = cbra_pkg::S_SEARCH;
                        end
                    end else begin
                        res_owner_next = s_owner_slot;
                        if (!slot_ok) begin
                            res_status_next = cbra_pkg::ST_NOT_USED;
                            state_next      = cbra_pkg::S_DONE;
                        end else begin
                            mval_next             = 1'b0;
                            in_use_next[slot_idx] = 1'b0;
                            res_status_next       = cbra_pkg::ST_OK;
                            state_next            = cbra_pkg::S_MARK;
                        end
                    end
                end
            end
            cbra_pkg::S_SEARCH: begin
                map_next = {map_reg[0], map_reg[cbra_pkg::ENTRY_COUNT-1:1]};
                idx_next = idx_reg + cbra_pkg::idx_t'(1);
                if (!found_reg) begin
                    if (!map_reg[0]) begin
                        run_next = run_inc;
                        if (run_inc >= len_reg) begin
                            found_next = 1'b1;
                            pos_next   = cbra_pkg::idx_t'(cbra_pkg::len_t'(idx_reg)
                                         + cbra_pkg::len_t'(1) - len_reg);
                        end
                    end else begin
                        run_next = '0;
                    end
                end
                if (last_idx) begin
                    idx_next = '0;
                    if (found_next) begin
                        mstart_next          = pos_next;
                        mval_next            = 1'b1;
                        tbl_we               = 1'b1;
                        in_use_next[own_reg] = 1'b1;
                        res_status_next      = cbra_pkg::ST_OK;
                        res_owner_next       = cbra_pkg::slot_t'(own_reg);
                        res_start_next       = cbra_pkg::start_t'(pos_next);
                        state_next           = cbra_pkg::S_MARK;
                    end else begin
                        res_status_next = cbra_pkg::ST_NO_ROOM;
                        res_owner_next  = '0;
                        state_next      = cbra_pkg::S_DONE;
                    end
                end
            end
            cbra_pkg::S_MARK: begin
                map_next = {new_bit, map_reg[cbra_pkg::ENTRY_COUNT-1:1]};
                idx_next = idx_reg + cbra_pkg::idx_t'(1);
                if (last_idx) begin
                    idx_next = '0;
                    if (!mval_reg) begin
                        res_start_next = cbra_pkg::start_t'(rd_start_reg);
                    end
                    state_next = cbra_pkg::S_DONE;
                end
            end
            cbra_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_owner_next  = res_owner_reg;
                    m_start_next  = res_start_reg;
                    state_next    = cbra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cbra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cbra_pkg::S_IDLE;
            map_reg     <= '0;
            in_use_reg  <= '0;
            idx_reg     <= '0;
            run_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            map_reg     <= map_next;
            in_use_reg  <= in_use_next;
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        len_reg        <= len_next;
        own_reg        <= own_next;
        mstart_reg     <= mstart_next;
        mval_reg       <= mval_next;
        res_status_reg <= res_status_next;
        res_owner_reg  <= res_owner_next;
        res_start_reg  <= res_start_next;
        m_status_reg   <= m_status_next;
        m_owner_reg    <= m_owner_next;
        m_start_reg    <= m_start_next;
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            owner_start_mem[own_reg]  <= pos_next;
            owner_length_mem[own_reg] <= len_reg;
        end
        if (state_reg == cbra_pkg::S_IDLE) begin
            rd_start_reg <= owner_start_mem[slot_idx];
            rd_len_reg   <= owner_length_mem[slot_idx];
        end
    end

    assign s_ready         = (state_reg == cbra_pkg::S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_owner = m_owner_reg;
    assign m_start_index   = m_start_reg;

endmodule

// ----- rtl/cbra_checker.sv -----
`include "assert_macros.svh"

module cbra_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [cbra_pkg::STATUS_W-1:0] m_status,
    input logic [cbra_pkg::SLOT_W-1:0]   m_granted_owner,
    input logic [cbra_pkg::START_W-1:0]  m_start_index
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_owner) && $stable(m_start_index), "result changed while stalled")
    `ASSERT_CLK(a_busy_after_take, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request taken while one is in work")
    `ASSERT_CLK_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result shown after reset")
    `ASSERT_CLK(a_reject_zero, aclk, aresetn, m_valid && (m_status == cbra_pkg::ST_NO_OWNER || m_status == cbra_pkg::ST_NO_ROOM) |-> m_granted_owner == '0 && m_start_index == '0, "rejected allocate carries owner or start")

endmodule

bind contiguous_bitmap_region_allocator_unit cbra_checker u_cbra_checker (.*);

// ----- tb/sv/contiguous_bitmap_region_allocator_unit_test.sv -----
`timescale 1ns / 1ps

module contiguous_bitmap_region_allocator_unit_test;

    localparam int ITEM_LATENCY = 2 * cbra_pkg::ENTRY_COUNT + 2;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 1500;

    typedef logic [cbra_pkg::DIM_W-1:0] dim_t;

    typedef struct packed {
        cbra_pkg::status_t status;
        cbra_pkg::slot_t   owner;
        cbra_pkg::start_t  start;
    } region_result_t;

    logic                                aclk;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic                                s_operation    = 1'b0;
    logic [cbra_pkg::DIM_W-1:0]          s_row_count    = '0;
    logic [cbra_pkg::DIM_W-1:0]          s_column_count = '0;
    logic [cbra_pkg::SLOT_W-1:0]         s_owner_slot   = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [cbra_pkg::STATUS_W-1:0]       m_status;
    logic [cbra_pkg::SLOT_W-1:0]         m_granted_owner;
    logic [cbra_pkg::START_W-1:0]        m_start_index;

    bit [cbra_pkg::ENTRY_COUNT-1:0]      busy_map;
    bit [cbra_pkg::OWNER_COUNT-1:0]      owner_busy;
    cbra_pkg::start_t                    owner_base [cbra_pkg::OWNER_COUNT];
    int                                  owner_len [cbra_pkg::OWNER_COUNT];

    region_result_t       pending_results [$];
    int                   fail_count;
    int                   cycle_count;
    int                   hold_off_cycles;
    bit                   no_idle;
    int                   alloc_sent;
    int                   free_sent;
    int                   status_seen [4];

    contiguous_bitmap_region_allocator_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_row_count     (s_row_count),
        .s_column_count  (s_column_count),
        .s_owner_slot    (s_owner_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_owner (m_granted_owner),
        .m_start_index   (m_start_index)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
            end
        end
    end

    function automatic region_result_t predict_request(cbra_pkg::op_t op, dim_t rows,
                                                       dim_t cols, cbra_pkg::slot_t slot);
        region_result_t res;
        int run_len;
        int free_run;
        int base;
        int owner;
        res.status = cbra_pkg::ST_NO_ROOM;
        res.owner  = '0;
        res.start  = '0;
        if (op == cbra_pkg::OP_ALLOC) begin
            owner = -1;
            for (int i = 0; i < cbra_pkg::OWNER_COUNT; i++) begin
                if (!owner_busy[i] && owner < 0) owner = i;
            end
            run_len = int'(rows) * int'(cols);
            if (owner < 0) begin
                res.status = cbra_pkg::ST_NO_OWNER;
            end else begin
                base = -1;
                if (run_len > 0 && run_len <= cbra_pkg::ENTRY_COUNT) begin
                    free_run = 0;
                    for (int i = 0; i < cbra_pkg::ENTRY_COUNT; i++) begin
                        if (!busy_map[i]) begin
                            free_run++;
                            if (free_run >= run_len && base < 0) base = i + 1 - run_len;
                        end else begin
                            free_run = 0;
                        end
                    end
                end
                if (base >= 0) begin
                    for (int i = base; i < base + run_len; i++) busy_map[i] = 1'b1;
                    owner_busy[owner] = 1'b1;
                    owner_base[owner] = cbra_pkg::start_t'(base);
                    owner_len[owner]  = run_len;
                    res.status = cbra_pkg::ST_OK;
                    res.owner  = cbra_pkg::slot_t'(owner);
                    res.start  = cbra_pkg::start_t'(base);
                end
            end
        end else begin
            res.owner = slot;
            if (int'(slot) >= cbra_pkg::OWNER_COUNT || !owner_busy[slot]) begin
                res.status = cbra_pkg::ST_NOT_USED;
            end else begin
                for (int i = owner_base[slot]; i < owner_base[slot] + owner_len[slot]; i++)
                    if (i < cbra_pkg::ENTRY_COUNT) busy_map[i] = 1'b0;
                owner_busy[slot] = 1'b0;
                res.status = cbra_pkg::ST_OK;
                res.start  = owner_base[slot];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        region_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d owner %0d start %0d",
                       m_status, m_granted_owner, m_start_index);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                status_seen[int'(want.status)]++;
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_granted_owner !== want.owner) begin
                    $error("granted_owner mismatch: expected %0d, actual %0d",
                           want.owner, m_granted_owner);
                    fail_count++;
                end
                if (m_start_index !== want.start) begin
                    $error("start_index mismatch: expected %0d, actual %0d",
                           want.start, m_start_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(cbra_pkg::op_t op, dim_t rows, dim_t cols,
                                cbra_pkg::slot_t slot);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 8) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_row_count    <= rows;
        s_column_count <= cols;
        s_owner_slot   <= slot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == cbra_pkg::OP_ALLOC) alloc_sent++;
        else free_sent++;
        pending_results.push_back(predict_request(op, rows, cols, slot));
    endtask

    task automatic wait_for_results();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic release_all_owners();
        for (int i = 0; i < cbra_pkg::OWNER_COUNT; i++) begin
            if (owner_busy[i])
                send_request(cbra_pkg::OP_FREE, dim_t'($urandom_range(15)),
                             dim_t'($urandom_range(15)), cbra_pkg::slot_t'(i));
        end
        wait_for_results();
    endtask

    task automatic test_directed_cases();
        send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0, 3'd0);
        send_request(cbra_pkg::OP_FREE, 4'd15, 4'd15, 3'd7);
        send_request(cbra_pkg::OP_ALLOC, 4'd0, 4'd5, 3'd0);
        send_request(cbra_pkg::OP_ALLOC, 4'd3, 4'd0, 3'd7);
        send_request(cbra_pkg::OP_ALLOC, 4'd15, 4'd15, 3'd7);
        send_request(cbra_pkg::OP_ALLOC, 4'd8, 4'd8, 3'd0);
        send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd1, 3'd0);
        send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0, 3'd0);
        for (int i = 0; i < cbra_pkg::OWNER_COUNT; i++)
            send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd1, 3'd0);
        send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd1, 3'd0);
        send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0, 3'd3);
        send_request(cbra_pkg::OP_ALLOC, 4'd2, 4'd1, 3'd0);
        send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd1, 3'd0);
        send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0, 3'd5);
        send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0, 3'd3);
        send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd3, 3'd0);
        wait_for_results();
        release_all_owners();
    endtask

    task automatic test_output_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 10; i++) begin
            if (i % 3 == 2)
                send_request(cbra_pkg::OP_ALLOC, 4'd1, 4'd2,
                             cbra_pkg::slot_t'($urandom_range(7)));
            else
                send_request(cbra_pkg::OP_FREE, 4'd0, 4'd0,
                             cbra_pkg::slot_t'($urandom_range(7)));
        end
        wait_for_results();
        release_all_owners();
    endtask

    task automatic test_random_traffic();
        int kind;
        int candidates [$];
        cbra_pkg::op_t op;
        dim_t rows;
        dim_t cols;
        cbra_pkg::slot_t slot;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 500 && n < 800);
            kind = $urandom_range(99);
            rows = dim_t'($urandom_range(15));
            cols = dim_t'($urandom_range(15));
            slot = cbra_pkg::slot_t'($urandom_range(7));
            if (kind < 45) begin
                op   = cbra_pkg::OP_ALLOC;
                rows = dim_t'($urandom_range(1, 3));
                cols = dim_t'($urandom_range(1, 4));
            end else if (kind < 48) begin
                op   = cbra_pkg::OP_ALLOC;
                rows = dim_t'($urandom_range(5, 8));
                cols = 4'd8;
            end else if (kind < 80) begin
                op = cbra_pkg::OP_FREE;
                candidates.delete();
                for (int i = 0; i < cbra_pkg::OWNER_COUNT; i++)
                    if (owner_busy[i]) candidates.push_back(i);
                if (candidates.size() != 0)
                    slot = cbra_pkg::slot_t'(candidates[$urandom_range(candidates.size() - 1)]);
            end else begin
                op = $urandom_range(1) ? cbra_pkg::OP_FREE : cbra_pkg::OP_ALLOC;
            end
            send_request(op, rows, cols, slot);
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_output_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (ITEM_LATENCY + 8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Sent %0d requests (%0d allocate, %0d free) in %0d cycles.",
                 alloc_sent + free_sent, alloc_sent, free_sent, cycle_count);
        $display("Results seen: %0d ok, %0d no owner, %0d no room, %0d owner idle.",
                 status_seen[int'(cbra_pkg::ST_OK)],
                 status_seen[int'(cbra_pkg::ST_NO_OWNER)],
                 status_seen[int'(cbra_pkg::ST_NO_ROOM)],
                 status_seen[int'(cbra_pkg::ST_NOT_USED)]);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
